// ----- rtl/core/mf3_pkg.sv -----
`default_nettype none

package mf3_pkg;

  // pixel and window types
  typedef logic [7:0] pix_t;
  typedef logic [2:0][2:0][7:0] win_t;   // [row][col], col 2 is the newest

  // configuration register widths and reset values
  localparam int FW_BITS = 11;
  localparam int FH_BITS = 13;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

  // line store entry: previous row in the upper byte, the row before in the lower
  localparam int LINE_BITS = 16;

  // configuration register index
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // kind of item held in the read stage
  typedef enum logic [1:0] {
    K_PIXEL     = 2'd0,
    K_DRAIN_WIN = 2'd1,
    K_DRAIN_MEM = 2'd2
  } item_kind_t;

  // request into the median pipeline
  typedef struct packed {
    win_t win;
    pix_t byp;
    logic use_med;
    logic last;
  } med_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/median_filter_3x3.sv -----
// median_filter_3x3: streaming 3x3 median filter over raster-order 8-bit pixels
// a result is registered in the read stage, median stages a and b, then the output register
// one item per cycle unless stalled, set by the single read and write port of the line store
// the outputs of a pixel leave frame_width+1 items after it, pushed by later pixels or drains
// reset (rst_n, synchronous): position, pending count, window and pipeline valids clear,
// size registers return to 640x480; the line store is not cleared and needs no clearing pass
`default_nettype none

module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_pixel_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_pixel_out,
  output logic             out_frame_last
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);       // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int PW = $clog2(MAX_WIDTH + 2);   // pending count, up to width+1

  function automatic logic [WW-1:0] clamp_w(input logic [FW_BITS-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd3) begin
      x = 32'd3;
    end else if (x > 32'(MAX_WIDTH)) begin
      x = 32'(MAX_WIDTH);
    end
    return x[WW-1:0];
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [FH_BITS-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd3) begin
      x = 32'd3;
    end else if (x > 32'(MAX_HEIGHT)) begin
      x = 32'(MAX_HEIGHT);
    end
    return x[HW-1:0];
  endfunction

  // configuration registers
  logic [FW_BITS-1:0] fw_raw_r;
  logic [FH_BITS-1:0] fh_raw_r;
  logic [WW-1:0]      eff_w_r;
  logic [HW-1:0]      eff_h_r;

  // stream position and owed outputs
  logic [AW-1:0] col_r,  col_nxt;
  logic [RW-1:0] row_r,  row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  win_t          win_r,  win_nxt;

  // read stage
  logic       s1_v_r,  s1_v_nxt;
  item_kind_t s1_kind_r;
  logic       s1_emit_r;
  pix_t       s1_px_r;
  logic [AW-1:0] s1_addr_r;
  logic       s1_med_r;
  logic       s1_last_r;

  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  logic          in_xfer;
  logic [PW-1:0] w_p1;
  logic [PW-1:0] drain_diff;
  logic [AW-1:0] rd_addr;
  logic          drain_ok;
  logic          win_drain;
  logic          pix_emit;
  logic          col_wrap;
  logic          row_wrap;
  item_kind_t    s0_kind;
  logic          s0_emit;
  logic          s0_med;
  logic          s0_last;
  logic          s1_go;

  logic [LINE_BITS-1:0] mem_rdata;
  logic                 mem_we;
  pix_t                 rd_a;
  pix_t                 rd_b;
  win_t                 win_shift;
  med_req_t             req;
  logic                 req_ready;

  // apb access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(fw_raw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_raw_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_raw_r <= FW_RESET;
      fh_raw_r <= FH_RESET;
      eff_w_r  <= clamp_w(FW_RESET);
      eff_h_r  <= clamp_h(FH_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH: begin
          fw_raw_r <= pwdata[FW_BITS-1:0];
          eff_w_r  <= clamp_w(pwdata[FW_BITS-1:0]);
        end
        REG_FRAME_HEIGHT: begin
          fh_raw_r <= pwdata[FH_BITS-1:0];
          eff_h_r  <= clamp_h(pwdata[FH_BITS-1:0]);
        end
        default: begin
          fw_raw_r <= fw_raw_r;
        end
      endcase
    end
  end

  // input stage: position bookkeeping and decision on each item
  assign in_ready   = !s1_v_r || s1_go;
  assign in_xfer    = in_valid && in_ready;
  assign w_p1       = PW'(eff_w_r) + PW'(1);
  assign drain_diff = PW'(eff_w_r) - pend_r;
  assign drain_ok   = (pend_r != '0) && (col_r == '0) && (row_r == '0);
  assign win_drain  = pend_r >= w_p1;
  assign pix_emit   = pend_r >= w_p1;
  assign col_wrap   = (WW'(col_r) + WW'(1)) >= eff_w_r;
  assign row_wrap   = (HW'(row_r) + HW'(1)) >= eff_h_r;
  assign rd_addr    = in_mode ? drain_diff[AW-1:0] : col_r;

  always_comb begin
    if (!in_mode) begin
      s0_kind = K_PIXEL;
      s0_emit = pix_emit;
      s0_med  = (col_r >= AW'(2)) && (row_r >= RW'(2));
      s0_last = (col_r == '0) && (row_r == RW'(1));
    end else begin
      s0_kind = win_drain ? K_DRAIN_WIN : K_DRAIN_MEM;
      s0_emit = 1'b1;
      s0_med  = 1'b0;
      s0_last = !win_drain && (pend_r == PW'(1));
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    priority if (cfg_wr) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (in_xfer && !in_mode) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
      pend_nxt = pix_emit ? w_p1 : pend_r + PW'(1);
    end else if (in_xfer && drain_ok) begin
      pend_nxt = win_drain ? PW'(eff_w_r) : pend_r - PW'(1);
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_ready) begin
      s1_v_nxt = in_valid && (!in_mode || drain_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      win_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      win_r  <= win_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= s0_kind;
      s1_emit_r <= s0_emit;
      s1_px_r   <= in_pixel_in;
      s1_addr_r <= col_r;
      s1_med_r  <= s0_med;
      s1_last_r <= s0_last;
    end
  end

  // line store: the same column is not read again until at least three
  // transfers later, so the write-back never races a read of its entry
  mf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr_r),
    .wdata ({s1_px_r, rd_a}),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // read stage: shift the window, write the rows back, hand off results
  assign rd_a   = mem_rdata[LINE_BITS-1 -: 8];
  assign rd_b   = mem_rdata[7:0];
  assign s1_go  = s1_v_r && (!s1_emit_r || req_ready);
  assign mem_we = s1_go && (s1_kind_r == K_PIXEL);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i][0] = win_r[i][1];
      win_shift[i][1] = win_r[i][2];
    end
    win_shift[0][2] = rd_b;
    win_shift[1][2] = rd_a;
    win_shift[2][2] = s1_px_r;
  end

  always_comb begin
    win_nxt = win_r;
    priority if (cfg_wr) begin
      win_nxt = '0;
    end else if (mem_we) begin
      win_nxt = win_shift;
    end else begin
      win_nxt = win_r;
    end
  end

  always_comb begin
    req.win     = win_shift;
    req.use_med = s1_med_r;
    req.last    = s1_last_r;
    unique case (s1_kind_r)
      K_DRAIN_MEM: req.byp = rd_a;
      K_PIXEL:     req.byp = win_r[1][2];
      K_DRAIN_WIN: req.byp = win_r[1][2];
      default:     req.byp = win_r[1][2];
    endcase
  end

  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_v_r && s1_emit_r),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_pixel (out_pixel_out),
    .res_last  (out_frame_last)
  );

  // owed outputs never exceed one row plus one pixel
  pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= w_p1)
    else $error("pending count beyond width+1");

  // input column stays inside the row
  col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < eff_w_r)
    else $error("column position beyond frame width");

  // input row stays inside the frame
  row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    HW'(row_r) < eff_h_r)
    else $error("row position beyond frame height");

  // a drain taken from the line store always has its result owed within the row
  drain_mem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_mode && drain_ok && !win_drain) |-> (pend_r <= PW'(eff_w_r)))
    else $error("line store drain outside the last row");

endmodule

`default_nettype wire

// ----- rtl/core/mf3_line_mem.sv -----
`default_nettype none

module mf3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [mf3_pkg::LINE_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [mf3_pkg::LINE_BITS-1:0] rdata
);
  import mf3_pkg::*;

  logic [LINE_BITS-1:0] mem_r [DEPTH];
  logic [LINE_BITS-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/mf3_median.sv -----
`default_nettype none

module mf3_median (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire mf3_pkg::med_req_t req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mf3_pkg::pix_t          res_pixel,
  output logic                   res_last
);
  import mf3_pkg::*;

  function automatic pix_t max2(input pix_t x, input pix_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic pix_t min2(input pix_t x, input pix_t y);
    return (x < y) ? x : y;
  endfunction

  // three compare-exchanges, result [0] lowest
  function automatic logic [2:0][7:0] sort3(input pix_t x0, input pix_t x1, input pix_t x2);
    pix_t l1;
    pix_t h1;
    pix_t m;
    pix_t hi;
    l1 = min2(x0, x1);
    h1 = max2(x0, x1);
    m  = min2(h1, x2);
    hi = max2(h1, x2);
    return {hi, max2(l1, m), min2(l1, m)};
  endfunction

  function automatic pix_t med3(input pix_t x, input pix_t y, input pix_t z);
    return max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  logic     a_v_r;
  med_req_t a_req_r;
  logic     b_v_r;
  pix_t     b_lo_r;
  pix_t     b_mid_r;
  pix_t     b_hi_r;
  pix_t     b_byp_r;
  logic     b_use_r;
  logic     b_last_r;
  logic     out_v_r;
  pix_t     out_pix_r;
  logic     out_last_r;

  logic            a_take;
  logic            b_take;
  logic            out_take;
  logic [2:0][2:0][7:0] col_sorted;   // [col][rank]
  pix_t            lo_max;
  pix_t            mid_med;
  pix_t            hi_min;

  // stage moves when it is empty or its content moves on
  assign out_take  = !out_v_r || res_ready;
  assign b_take    = !b_v_r || out_take;
  assign a_take    = !a_v_r || b_take;
  assign req_ready = a_take;

  // sort each column, then reduce lows, mids and highs
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      col_sorted[j] = sort3(a_req_r.win[0][j], a_req_r.win[1][j], a_req_r.win[2][j]);
    end
    lo_max  = max2(max2(col_sorted[0][0], col_sorted[1][0]), col_sorted[2][0]);
    mid_med = med3(col_sorted[0][1], col_sorted[1][1], col_sorted[2][1]);
    hi_min  = min2(min2(col_sorted[0][2], col_sorted[1][2]), col_sorted[2][2]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_v_r <= req_valid;
      end
      if (b_take) begin
        b_v_r <= a_v_r;
      end
      if (out_take) begin
        out_v_r <= b_v_r;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (a_take && req_valid) begin
      a_req_r <= req;
    end
    if (b_take && a_v_r) begin
      b_lo_r   <= lo_max;
      b_mid_r  <= mid_med;
      b_hi_r   <= hi_min;
      b_byp_r  <= a_req_r.byp;
      b_use_r  <= a_req_r.use_med;
      b_last_r <= a_req_r.last;
    end
    if (out_take && b_v_r) begin
      out_pix_r  <= b_use_r ? med3(b_lo_r, b_mid_r, b_hi_r) : b_byp_r;
      out_last_r <= b_last_r;
    end
  end

  assign res_valid = out_v_r;
  assign res_pixel = out_pix_r;
  assign res_last  = out_last_r;

  // a full stage that cannot move holds everything behind it
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && b_v_r && out_v_r && !res_ready) |-> !req_ready)
    else $error("median pipe took a request while full and stalled");

  // stage b holds its entry while the output stays full and blocked
  b_moves_only_on_space: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && out_v_r && !res_ready) |=> b_v_r)
    else $error("median pipe dropped an entry while stalled");

  // stage a drains into b the cycle after it is free to move
  a_feeds_b: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && b_take) |=> b_v_r)
    else $error("median pipe lost an entry between stages");

endmodule

`default_nettype wire

// ----- test/median_filter_3x3_tb.sv -----
`timescale 1ns / 1ps

module median_filter_3x3_tb;
  import mf3_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 150;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } filtered_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [7:0]  in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        out_frame_last;

  median_filter_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // filter state mirrored from the transfers seen on the ports
  logic [FW_BITS-1:0] width_reg;
  logic [FH_BITS-1:0] height_reg;
  pix_t               line_prev [MAX_W];
  pix_t               line_prev2 [MAX_W];
  pix_t               win [3][3];
  logic [9:0]         col_pos;
  logic [11:0]        row_pos;
  logic [10:0]        owed;
  filtered_t          filtered_q [$];

  int                 mismatch_count = 0;
  int                 stuck_cycles = 0;
  int                 burst_left = 1;
  bit                 pacing_on = 1'b1;
  int                 hold_requests = 0;
  int                 holds_served = 0;
  int                 hold_left = 0;
  int                 pattern_left = 0;
  ready_style_t       ready_style = RDY_ALWAYS;
  filtered_t          oldest;

  function automatic int clamp_size(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_stream();
    win = '{default: 8'd0};
    col_pos = '0;
    row_pos = '0;
    owed = '0;
  endfunction

  // middle of the nine window values by insertion sort
  function automatic pix_t median_of_window();
    pix_t vals [9];
    pix_t t;
    int   i, j;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        vals[i*3+j] = win[i][j];
    for (i = 1; i < 9; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    return vals[4];
  endfunction

  // one accepted input item, queues the result it releases if any
  function automatic void filter_item(input logic drain, input pix_t px);
    int        w, h, r, c, crow, ccol, i;
    pix_t      a, b;
    filtered_t res;
    w = clamp_size(int'(width_reg), 3, MAX_W);
    h = clamp_size(int'(height_reg), 3, MAX_H);
    if (drain) begin
      // flush only at a frame boundary with something owed
      if (owed == 0 || col_pos != 0 || row_pos != 0) return;
      if (owed >= w + 1) begin
        res.pixel = win[1][2];
        owed = 11'(w);
      end else begin
        res.pixel = line_prev[w - owed];
        owed = owed - 11'd1;
      end
      res.last = (owed == 0);
      filtered_q.push_back(res);
      return;
    end
    r = row_pos;
    c = col_pos;
    a = line_prev[c];
    b = line_prev2[c];
    line_prev2[c] = a;
    line_prev[c] = px;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = b;
    win[1][2] = a;
    win[2][2] = px;
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : 12'(r + 1);
    end else begin
      col_pos = 10'(c + 1);
    end
    owed = owed + 11'd1;
    if (owed < w + 2) return;
    owed = 11'(w + 1);
    // window center sits one row up and one column left
    if (c == 0) begin
      ccol = w - 1;
      crow = r - 2;
    end else begin
      ccol = c - 1;
      crow = r - 1;
    end
    if (crow < 0) crow += h;
    if (crow >= 1 && crow <= h - 2 && ccol >= 1 && ccol <= w - 2)
      res.pixel = median_of_window();
    else
      res.pixel = win[1][1];
    res.last = (crow == h - 1 && ccol == w - 1);
    filtered_q.push_back(res);
  endfunction

  function automatic void apply_config(input logic [2:0] addr, input logic [31:0] data);
    if (addr[1:0] != 2'b00) return;
    case (reg_idx_t'(addr[2]))
      REG_FRAME_WIDTH: begin
        width_reg = data[FW_BITS-1:0];
        restart_stream();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[FH_BITS-1:0];
        restart_stream();
      end
      default: ;
    endcase
  endfunction

  // track input and register transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      restart_stream();
    end else begin
      if (psel && penable && pwrite && pready) apply_config(paddr, pwdata);
      if (in_valid && in_ready) filter_item(in_mode, in_pixel_in);
    end
  end

  // compare each output transfer with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("ERROR: unexpected output pixel %0d last %0d",
                   out_pixel_out, out_frame_last);
        mismatch_count++;
      end else begin
        oldest = filtered_q.pop_front();
        if (oldest.pixel !== out_pixel_out || oldest.last !== out_frame_last) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("ERROR: expected pixel %0d last %0d, got pixel %0d last %0d",
                     oldest.pixel, oldest.last, out_pixel_out, out_frame_last);
          mismatch_count++;
        end
      end
    end
  end

  // output side backpressure, with long holds on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_style = ready_style_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      case (ready_style)
        RDY_ALWAYS:   out_ready <= 1'b1;
        RDY_MOSTLY:   out_ready <= ($urandom_range(0, 9) < 7);
        RDY_PERIODIC: out_ready <= (pattern_left % 4 != 0);
        default:      out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // offer one item and wait for its transfer, then maybe gap
  task automatic send_item(input logic drain, input pix_t px);
    in_valid <= 1'b1;
    in_mode <= drain;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pacing_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
      end
    end
  endtask

  task automatic send_pixels(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(1'b0, pix_t'($urandom));
  endtask

  task automatic send_drains(input int n);
    int i;
    for (i = 0; i < n; i++) send_item(1'b1, pix_t'($urandom));
  endtask

  // stop offering and wait for every expected pixel, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, junk in the bits above the field
  task automatic write_reg(input reg_idx_t idx, input int value);
    logic [31:0] field_mask;
    field_mask = (idx == REG_FRAME_WIDTH) ? (32'd1 << FW_BITS) - 1 : (32'd1 << FH_BITS) - 1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & ~field_mask) | (value & field_mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // 3x3 frames: extreme pixels, stray and partial drains, drain on empty
  task automatic test_directed();
    send_item(1'b1, 8'hFF);
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h55);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'hFE);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_drains(2);
    send_pixels(9);
    send_drains(4);
    send_item(1'b1, 8'hAA);
    wait_drained();
  endtask

  // frame size limits and out of range register values
  task automatic test_size_extremes();
    // oversize width clamps to the widest row, the restart drops what is still owed
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 5000);
    send_pixels(MAX_W + 4);
    wait_drained();
    // narrowest rows, oversize height clamps, drains in mid-frame do nothing
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 8191);
    send_pixels(24);
    send_drains(2);
    wait_drained();
    // undersize values act as three
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_pixels(18);
    send_drains(2);
    send_pixels(9);
    send_drains(4);
    wait_drained();
  endtask

  // output held off while input keeps coming, then a full pause mid-frame
  task automatic test_backpressure();
    write_reg(REG_FRAME_WIDTH, 8);
    write_reg(REG_FRAME_HEIGHT, 6);
    pacing_on = 1'b0;
    hold_requests++;
    send_pixels(80);
    wait_drained();
    send_pixels(16);
    pacing_on = 1'b1;
    send_drains(9);
    wait_drained();
  endtask

  // random small frames with random content, stray drains and cut frames
  task automatic test_random_stream();
    int done, w_raw, h_raw, w, h, frames, px_count, f, i, n;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       w_raw = $urandom_range(0, 2);
        1:       w_raw = $urandom_range(13, 40);
        default: w_raw = $urandom_range(3, 12);
      endcase
      h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      write_reg(REG_FRAME_WIDTH, w_raw);
      write_reg(REG_FRAME_HEIGHT, h_raw);
      w = clamp_size(w_raw, 3, MAX_W);
      h = clamp_size(h_raw, 3, MAX_H);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        px_count = w * h;
        if (f == frames - 1 && $urandom_range(0, 3) == 0)
          px_count = $urandom_range(1, w * h - 1);
        for (i = 0; i < px_count; i++) begin
          if ($urandom_range(0, 24) == 0) send_item(1'b1, pix_t'($urandom));
          send_item(1'b0, pix_t'($urandom));
          done++;
          if ($urandom_range(0, 299) == 0) wait_drained();
        end
        if (px_count == w * h) begin
          n = $urandom_range(0, w + 2);
          send_drains(n);
          done += n;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_extremes();
    test_backpressure();
    test_random_stream();
    wait_drained();
    if (mismatch_count == 0 && filtered_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
